@@ rtl/strided_2d_convolution_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the strided 2D convolution block
// Shared property forms, all clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef STRIDED_2D_CONVOLUTION_ASSERT_SVH
`define STRIDED_2D_CONVOLUTION_ASSERT_SVH

// Same-cycle implication.
`define S2D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define S2D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/s2dconv_pkg.sv @@
// ---------------------------------------------------------------------------
// s2dconv_pkg
// Types, constants and small helpers shared by the convolution block.
// ---------------------------------------------------------------------------
package s2dconv_pkg;

  localparam int MAX_KERNEL  = 5;
  localparam int MAX_COLS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = 37;
  localparam int WIDX_W      = 5;
  localparam int KDIM_W      = 3;
  localparam int IMG_W       = 9;
  localparam int POS_W       = 8;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int SLOT_W      = $clog2(MAX_KERNEL);
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ROW_W       = PROD_W + $clog2(MAX_KERNEL);
  localparam int STRIDE_MAX  = 5;
  localparam int IMG_MAX     = 256;

  typedef enum logic [2:0] {
    REG_KERNEL_ROWS = 3'd0,
    REG_KERNEL_COLS = 3'd1,
    REG_IMAGE_ROWS  = 3'd2,
    REG_IMAGE_COLS  = 3'd3,
    REG_STRIDE      = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic [WIDX_W-1:0]             weight_index;
    logic signed [SAMPLE_BITS-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    last;
  } out_beat_t;

  // One line-store word: one pixel for each of the MAX_KERNEL row slots.
  typedef logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] word_t;

  typedef struct packed {
    logic                          rd_en;
    logic [POS_W-1:0]              rd_col;
    logic                          wr_en;
    logic [POS_W-1:0]              wr_col;
    logic [SLOT_W-1:0]             wr_slot;
    logic signed [SAMPLE_BITS-1:0] wr_value;
  } lb_ctl_t;

  typedef struct packed {
    logic                          w_we;
    logic [WIDX_W-1:0]             w_idx;
    logic signed [SAMPLE_BITS-1:0] w_value;
    logic                          prod_en;
    logic                          row_en;
    logic [KDIM_W-1:0]             kr;
    logic [KDIM_W-1:0]             kc;
    logic [SLOT_W-1:0]             rslot;
  } mac_ctl_t;

  // Quotient of a small position by a stride of 1 to 5, by shift or reciprocal multiply.
  function automatic logic [POS_W-1:0] div_small(input logic [POS_W-1:0] x,
                                                 input logic [KDIM_W-1:0] s);
    logic [POS_W+9:0] p;
    p = '0;
    case (s)
      3'd2: return x >> 1;
      3'd3: begin
        p = {10'b0, x} * 18'd342;
        return p[POS_W+9:10];
      end
      3'd4: return x >> 2;
      3'd5: begin
        p = {10'b0, x} * 18'd205;
        return p[POS_W+9:10];
      end
      default: return x;
    endcase
  endfunction

endpackage

@@ rtl/s2dconv_linebuf.sv @@
// ---------------------------------------------------------------------------
// s2dconv_linebuf
// Line store of the last MAX_KERNEL rows, one word per column, read-modify-
// write with forwarding, and the column shift register that forms the window.
// ---------------------------------------------------------------------------
module s2dconv_linebuf #(
  parameter int MAX_COLS = s2dconv_pkg::MAX_COLS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  s2dconv_pkg::lb_ctl_t                       ctl,
  output s2dconv_pkg::word_t [s2dconv_pkg::MAX_KERNEL-1:0] win
);

  localparam int AW = $clog2(MAX_COLS);

  s2dconv_pkg::word_t mem [MAX_COLS];
  s2dconv_pkg::word_t rdata_r;
  s2dconv_pkg::word_t fwd_word_r;
  logic               fwd_r;
  s2dconv_pkg::word_t word_rd;
  s2dconv_pkg::word_t merged;
  s2dconv_pkg::word_t [s2dconv_pkg::MAX_KERNEL-1:0] win_r;

  // Take the word written in the cycle of the read when both hit one column.
  always_comb begin
    word_rd = fwd_r ? fwd_word_r : rdata_r;
    merged = word_rd;
    merged[ctl.wr_slot] = ctl.wr_value;
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[AW'(ctl.wr_col)] <= merged;
    end
    if (ctl.rd_en) begin
      rdata_r    <= mem[AW'(ctl.rd_col)];
      fwd_word_r <= merged;
    end
  end

  // Forwarding flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_r <= ctl.wr_en && (ctl.wr_col == ctl.rd_col);
    end
  end

  // Column shift register; entry 0 is the newest column.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      win_r[0] <= merged;
      for (int k = 1; k < s2dconv_pkg::MAX_KERNEL; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  assign win = win_r;

endmodule

@@ rtl/s2dconv_mac.sv @@
// ---------------------------------------------------------------------------
// s2dconv_mac
// Kernel weights, one multiplier per tap, per-row sums and the window total.
// ---------------------------------------------------------------------------
module s2dconv_mac (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  s2dconv_pkg::mac_ctl_t                            ctl,
  input  s2dconv_pkg::word_t [s2dconv_pkg::MAX_KERNEL-1:0] win,
  output logic signed [s2dconv_pkg::SUM_W-1:0]             sum
);

  localparam int MK = s2dconv_pkg::MAX_KERNEL;
  localparam int SB = s2dconv_pkg::SAMPLE_BITS;

  logic signed [SB-1:0]                    weight_r [MK*MK];
  logic signed [s2dconv_pkg::PROD_W-1:0]   prod_r   [MK][MK];
  logic signed [s2dconv_pkg::PROD_W-1:0]   prod_nxt [MK][MK];
  logic signed [s2dconv_pkg::ROW_W-1:0]    rowsum_r [MK];
  logic signed [s2dconv_pkg::ROW_W-1:0]    rowsum_nxt [MK];

  // Weight store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < MK*MK; n++) begin
        weight_r[n] <= '0;
      end
    end else if (ctl.w_we) begin
      weight_r[ctl.w_idx] <= ctl.w_value;
    end
  end

  // Pick each tap from the window and multiply; taps outside the kernel are zero.
  always_comb begin
    logic [s2dconv_pkg::SLOT_W:0]   t;
    logic [s2dconv_pkg::SLOT_W-1:0] sl;
    logic [s2dconv_pkg::KDIM_W-1:0] k;
    logic signed [SB-1:0]           px;
    for (int i = 0; i < MK; i++) begin
      for (int j = 0; j < MK; j++) begin
        t = (s2dconv_pkg::SLOT_W+1)'(ctl.rslot) + (s2dconv_pkg::SLOT_W+1)'(MK + 1 + i)
            - (s2dconv_pkg::SLOT_W+1)'(ctl.kr);
        if (t >= (s2dconv_pkg::SLOT_W+1)'(MK)) begin
          t = t - (s2dconv_pkg::SLOT_W+1)'(MK);
        end
        sl = t[s2dconv_pkg::SLOT_W-1:0];
        k  = ctl.kc - s2dconv_pkg::KDIM_W'(1) - s2dconv_pkg::KDIM_W'(j);
        px = win[k][sl];
        if ((s2dconv_pkg::KDIM_W'(i) < ctl.kr) && (s2dconv_pkg::KDIM_W'(j) < ctl.kc)) begin
          prod_nxt[i][j] = px * weight_r[i*MK+j];
        end else begin
          prod_nxt[i][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Sum each kernel row.
  always_comb begin
    for (int i = 0; i < MK; i++) begin
      rowsum_nxt[i] = '0;
      for (int j = 0; j < MK; j++) begin
        rowsum_nxt[i] = rowsum_nxt[i] + s2dconv_pkg::ROW_W'(prod_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.row_en) begin
      rowsum_r <= rowsum_nxt;
    end
  end

  // Window total.
  always_comb begin
    sum = '0;
    for (int i = 0; i < MK; i++) begin
      sum = sum + s2dconv_pkg::SUM_W'(rowsum_r[i]);
    end
  end

endmodule

@@ rtl/strided_2d_convolution.sv @@
// ---------------------------------------------------------------------------
// strided_2d_convolution
// Valid 2D convolution with stride over a raster pixel stream.
//
// The input channel carries weight-load beats (cmd 0) and pixel beats (cmd 1)
// on in_valid / in_stall / in_data. Pixels arrive in raster order. The result
// channel out_valid / out_stall / out_data gives one beat for each window that
// fits the frame at a stride position: the exact sum, its output row and
// column, and last on the frame's final window. The APB port sets kernel
// size, image size and stride; write it only while the block is idle.
//
// A pixel beat is taken every cycle while in_stall is low. Its result beat
// passes through line-store read, window merge and divide, one multiplier
// per tap, row sums, then the output register. Throughput is one pixel per
// clock while out_stall is low, set by the line store, which takes one read
// and one write each cycle (a column word is forwarded when consecutive
// pixels share it). While out_stall is high the pipeline keeps taking beats
// until its stages fill, then raises in_stall. Reset empties the pipeline,
// clears the weights, restores the register defaults and puts the position
// at row 0, column 0. The line store needs no clearing pass.
// ---------------------------------------------------------------------------
`include "strided_2d_convolution_assert.svh"

module strided_2d_convolution #(
  parameter int MAX_COLS = s2dconv_pkg::MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  s2dconv_pkg::in_beat_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output s2dconv_pkg::out_beat_t              out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [s2dconv_pkg::APB_AW-1:0]      paddr,
  input  logic [s2dconv_pkg::APB_DW-1:0]      pwdata,
  output logic [s2dconv_pkg::APB_DW-1:0]      prdata,
  output logic                                pready
);

  localparam int KW = s2dconv_pkg::KDIM_W;
  localparam int IW = s2dconv_pkg::IMG_W;
  localparam int PW = s2dconv_pkg::POS_W;
  localparam int SW = s2dconv_pkg::SLOT_W;
  localparam int SB = s2dconv_pkg::SAMPLE_BITS;
  localparam int IC_MAX = (MAX_COLS < s2dconv_pkg::IMG_MAX) ? MAX_COLS : s2dconv_pkg::IMG_MAX;

  // Configuration registers.
  logic [KW-1:0] krows_r, kcols_r, stride_r;
  logic [IW-1:0] irows_r, icols_r;
  s2dconv_pkg::reg_idx_t reg_sel;
  logic cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = s2dconv_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krows_r  <= KW'(3);
      kcols_r  <= KW'(3);
      irows_r  <= IW'(28);
      icols_r  <= IW'(28);
      stride_r <= KW'(1);
    end else if (cfg_we) begin
      case (reg_sel)
        s2dconv_pkg::REG_KERNEL_ROWS: krows_r  <= pwdata[KW-1:0];
        s2dconv_pkg::REG_KERNEL_COLS: kcols_r  <= pwdata[KW-1:0];
        s2dconv_pkg::REG_IMAGE_ROWS:  irows_r  <= pwdata[IW-1:0];
        s2dconv_pkg::REG_IMAGE_COLS:  icols_r  <= pwdata[IW-1:0];
        s2dconv_pkg::REG_STRIDE:      stride_r <= pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      s2dconv_pkg::REG_KERNEL_ROWS: prdata = s2dconv_pkg::APB_DW'(krows_r);
      s2dconv_pkg::REG_KERNEL_COLS: prdata = s2dconv_pkg::APB_DW'(kcols_r);
      s2dconv_pkg::REG_IMAGE_ROWS:  prdata = s2dconv_pkg::APB_DW'(irows_r);
      s2dconv_pkg::REG_IMAGE_COLS:  prdata = s2dconv_pkg::APB_DW'(icols_r);
      s2dconv_pkg::REG_STRIDE:      prdata = s2dconv_pkg::APB_DW'(stride_r);
      default:                      prdata = '0;
    endcase
  end

  // Effective (saturated) settings.
  logic [KW-1:0] kr_e, kc_e, s_e;
  logic [IW-1:0] ir_e, ic_e;

  always_comb begin
    kr_e = (krows_r == '0) ? KW'(1) :
           (krows_r > KW'(s2dconv_pkg::MAX_KERNEL)) ? KW'(s2dconv_pkg::MAX_KERNEL) : krows_r;
    kc_e = (kcols_r == '0) ? KW'(1) :
           (kcols_r > KW'(s2dconv_pkg::MAX_KERNEL)) ? KW'(s2dconv_pkg::MAX_KERNEL) : kcols_r;
    s_e  = (stride_r == '0) ? KW'(1) :
           (stride_r > KW'(s2dconv_pkg::STRIDE_MAX)) ? KW'(s2dconv_pkg::STRIDE_MAX) : stride_r;
    ir_e = (irows_r == '0) ? IW'(1) :
           (irows_r > IW'(s2dconv_pkg::IMG_MAX)) ? IW'(s2dconv_pkg::IMG_MAX) : irows_r;
    ic_e = (icols_r == '0) ? IW'(1) :
           (icols_r > IW'(IC_MAX)) ? IW'(IC_MAX) : icols_r;
  end

  // Pipeline valid bits and advance conditions.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_valid_r;
  logic s1_vld_nxt, s2_vld_nxt, s3_vld_nxt, s4_vld_nxt, out_valid_nxt;
  logic s1_adv, s2_adv, s3_adv, s4_adv, out_free, in_acc;

  // Stage payloads.
  s2dconv_pkg::cmd_t    s1_cmd_r, s2_cmd_r;
  logic [s2dconv_pkg::WIDX_W-1:0] s1_widx_r, s2_widx_r;
  logic signed [SB-1:0] s1_value_r, s2_value_r;
  logic [PW-1:0]        s1_col_r, s1_tr_r, s1_tc_r;
  logic [SW-1:0]        s1_slot_r, s2_slot_r;
  logic                 s1_inframe_r, s1_hit_r, s2_res_r;
  logic [PW-1:0]        s2_row_r, s2_col_r, s3_row_r, s3_col_r, s4_row_r, s4_col_r;
  logic                 s2_last_r, s3_last_r, s4_last_r;
  s2dconv_pkg::out_beat_t out_data_r;

  // Position of the next pixel.
  logic [PW-1:0] pos_row_r, pos_col_r;
  logic [SW-1:0] row_slot_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s4_adv   = s4_vld_r && out_free;
  assign s3_adv   = s3_vld_r && (!s4_vld_r || s4_adv);
  assign s2_adv   = s2_vld_r && (!s3_vld_r || s3_adv);
  assign s1_adv   = s1_vld_r && (!s2_vld_r || s2_adv);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Entry stage: frame position and window tests for the incoming beat.
  logic          is_pix, inframe0, hit0, row_end, frame_end;
  logic [IW-1:0] r9, c9;
  logic [PW-1:0] tr0, tc0;

  always_comb begin
    is_pix    = in_data.cmd == s2dconv_pkg::CMD_PIXEL;
    r9        = {1'b0, pos_row_r};
    c9        = {1'b0, pos_col_r};
    inframe0  = (r9 < ir_e) && (c9 < ic_e);
    hit0      = inframe0 && (r9 + IW'(1) >= IW'(kr_e)) && (c9 + IW'(1) >= IW'(kc_e));
    tr0       = PW'(r9 + IW'(1) - IW'(kr_e));
    tc0       = PW'(c9 + IW'(1) - IW'(kc_e));
    row_end   = c9 + IW'(1) >= ic_e;
    frame_end = r9 + IW'(1) >= ir_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r  <= '0;
      pos_col_r  <= '0;
      row_slot_r <= '0;
    end else if (in_acc && is_pix) begin
      if (row_end) begin
        pos_col_r <= '0;
        if (frame_end) begin
          pos_row_r  <= '0;
          row_slot_r <= '0;
        end else begin
          pos_row_r  <= pos_row_r + PW'(1);
          row_slot_r <= (row_slot_r == SW'(s2dconv_pkg::MAX_KERNEL - 1)) ? '0
                        : row_slot_r + SW'(1);
        end
      end else begin
        pos_col_r <= pos_col_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r     <= in_data.cmd;
      s1_widx_r    <= in_data.weight_index;
      s1_value_r   <= in_data.value;
      s1_col_r     <= pos_col_r;
      s1_slot_r    <= row_slot_r;
      s1_inframe_r <= inframe0;
      s1_hit_r     <= hit0;
      s1_tr_r      <= tr0;
      s1_tc_r      <= tc0;
    end
  end

  // Second stage: stride phase, output position and last flag.
  logic [PW-1:0] qr, qc, lqr, lqc;
  logic          rzr, rzc, last1, res1, s1_pix;

  always_comb begin
    s1_pix = s1_cmd_r == s2dconv_pkg::CMD_PIXEL;
    qr     = s2dconv_pkg::div_small(s1_tr_r, s_e);
    qc     = s2dconv_pkg::div_small(s1_tc_r, s_e);
    rzr    = s1_tr_r == PW'({3'b0, qr} * {8'b0, s_e});
    rzc    = s1_tc_r == PW'({3'b0, qc} * {8'b0, s_e});
    lqr    = s2dconv_pkg::div_small(PW'(ir_e - IW'(kr_e)), s_e);
    lqc    = s2dconv_pkg::div_small(PW'(ic_e - IW'(kc_e)), s_e);
    last1  = (ir_e >= IW'(kr_e)) && (ic_e >= IW'(kc_e)) && (qr == lqr) && (qc == lqc);
    res1   = s1_pix && s1_hit_r && rzr && rzc;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_widx_r  <= s1_widx_r;
      s2_value_r <= s1_value_r;
      s2_res_r   <= res1;
      s2_row_r   <= qr;
      s2_col_r   <= qc;
      s2_last_r  <= last1;
      s2_slot_r  <= s1_slot_r;
    end
    if (s2_adv) begin
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;
    end
    if (s3_adv) begin
      s4_row_r  <= s3_row_r;
      s4_col_r  <= s3_col_r;
      s4_last_r <= s3_last_r;
    end
  end

  // Valid bits of the stages.
  always_comb begin
    s1_vld_nxt    = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    s2_vld_nxt    = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_r);
    s3_vld_nxt    = s2_adv ? s2_res_r : (s3_adv ? 1'b0 : s3_vld_r);
    s4_vld_nxt    = s3_adv ? 1'b1 : (s4_adv ? 1'b0 : s4_vld_r);
    out_valid_nxt = s4_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      s3_vld_r    <= s3_vld_nxt;
      s4_vld_r    <= s4_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Line store and window.
  s2dconv_pkg::lb_ctl_t  lb_ctl;
  s2dconv_pkg::word_t [s2dconv_pkg::MAX_KERNEL-1:0] win;

  always_comb begin
    lb_ctl.rd_en    = in_acc && is_pix;
    lb_ctl.rd_col   = pos_col_r;
    lb_ctl.wr_en    = s1_adv && s1_pix && s1_inframe_r;
    lb_ctl.wr_col   = s1_col_r;
    lb_ctl.wr_slot  = s1_slot_r;
    lb_ctl.wr_value = s1_value_r;
  end

  s2dconv_linebuf #(
    .MAX_COLS (MAX_COLS)
  ) u_linebuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lb_ctl),
    .win   (win)
  );

  // Multiply and accumulate.
  s2dconv_pkg::mac_ctl_t     mac_ctl;
  logic signed [s2dconv_pkg::SUM_W-1:0] mac_sum;

  always_comb begin
    mac_ctl.w_we    = s2_adv && (s2_cmd_r == s2dconv_pkg::CMD_WEIGHT) &&
                      (s2_widx_r < s2dconv_pkg::WIDX_W'(s2dconv_pkg::MAX_KERNEL *
                                                       s2dconv_pkg::MAX_KERNEL));
    mac_ctl.w_idx   = s2_widx_r;
    mac_ctl.w_value = s2_value_r;
    mac_ctl.prod_en = s2_adv && s2_res_r;
    mac_ctl.row_en  = s3_adv;
    mac_ctl.kr      = kr_e;
    mac_ctl.kc      = kc_e;
    mac_ctl.rslot   = s2_slot_r;
  end

  s2dconv_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .win   (win),
    .sum   (mac_sum)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (s4_adv) begin
      out_data_r.sum     <= mac_sum;
      out_data_r.out_row <= s4_row_r;
      out_data_r.out_col <= s4_col_r;
      out_data_r.last    <= s4_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks.
  localparam logic [SW-1:0] SLOT_LAST = SW'(s2dconv_pkg::MAX_KERNEL - 1);
  logic s2_wgt_adv;

  assign s2_wgt_adv = s2_adv && (s2_cmd_r == s2dconv_pkg::CMD_WEIGHT);

  `S2D_ASSERT_IMP(a_stall_needs_s1, in_stall, s1_vld_r, "input stalled with entry stage empty")
  `S2D_ASSERT_NXT(a_weight_no_result, s2_wgt_adv, !s3_vld_r, "weight beat produced a result")
  `S2D_ASSERT_IMP(a_slot_range, 1'b1, row_slot_r <= SLOT_LAST, "row slot out of range")
  `S2D_ASSERT_NXT(a_out_from_s4, s4_adv, out_valid_r, "result lost on its way to the output")

endmodule

@@ dv/strided_2d_convolution_tb.sv @@
// ---------------------------------------------------------------------------
// Strided 2D convolution testbench
// Streams weight and pixel beats through the block and checks every window
// sum, position and last flag against a behavioral convolution predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module strided_2d_convolution_tb;

  typedef s2dconv_pkg::in_beat_t  in_beat_t;
  typedef s2dconv_pkg::out_beat_t out_beat_t;
  typedef s2dconv_pkg::reg_idx_t  reg_idx_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [s2dconv_pkg::APB_AW-1:0] paddr = '0;
  logic [s2dconv_pkg::APB_DW-1:0] pwdata = '0;
  logic [s2dconv_pkg::APB_DW-1:0] prdata;
  logic      pready;

  strided_2d_convolution u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, kernel, line store and raster position.
  logic [2:0]  k_rows_q, k_cols_q, stride_q;
  logic [8:0]  i_rows_q, i_cols_q;
  logic signed [15:0] weights_q [25];
  logic signed [15:0] lines_q [1280];
  int unsigned pos_row, pos_col;
  out_beat_t   window_q [$];
  out_beat_t   pred_q;
  bit          pred_hit = 1'b0;
  int          errors = 0;
  bit          stall_mode = 1'b0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Runs one input beat through the predictor; queues a window if one closes.
  task automatic predict_beat(input in_beat_t b);
    int unsigned kr, kc, ir, ic, s, r, c, tr, tc, lr, lc;
    longint acc;
    out_beat_t o;
    pred_hit = 1'b0;
    kr = clampu(k_rows_q, 1, 5); kc = clampu(k_cols_q, 1, 5);
    ir = clampu(i_rows_q, 1, 256); ic = clampu(i_cols_q, 1, 256);
    s = clampu(stride_q, 1, 5);
    r = pos_row; c = pos_col;
    if (b.cmd == s2dconv_pkg::CMD_WEIGHT) begin
      if (b.weight_index < 25) weights_q[b.weight_index] = b.value;
      return;
    end
    if (r < ir && c < ic) begin
      lines_q[(r % 5) * 256 + c] = b.value;
      if (r + 1 >= kr && c + 1 >= kc) begin
        tr = r + 1 - kr; tc = c + 1 - kc;
        if (tr % s == 0 && tc % s == 0) begin
          acc = 0;
          for (int i = 0; i < kr; i++)
            for (int j = 0; j < kc; j++)
              acc += longint'(lines_q[((tr + i) % 5) * 256 + tc + j]) *
                     longint'(weights_q[i * 5 + j]);
          lr = ((ir - kr) / s) * s; lc = ((ic - kc) / s) * s;
          o.sum = acc[36:0];
          o.out_row = 8'(tr / s);
          o.out_col = 8'(tc / s);
          o.last = (tr == lr && tc == lc);
          window_q = {window_q, o};
          pred_q = o;
          pred_hit = 1'b1;
        end
      end
    end
    if (c + 1 >= ic) begin
      pos_col = 0;
      pos_row = (r + 1 >= ir) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one beat, waits for acceptance, then models it.
  task automatic send_beat(input in_beat_t b);
    int g;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every queued window has come out, plus pipeline drain.
  task automatic drain();
    idle_input();
    while (window_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= s2dconv_pkg::APB_AW'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      s2dconv_pkg::REG_KERNEL_ROWS: k_rows_q = val[2:0];
      s2dconv_pkg::REG_KERNEL_COLS: k_cols_q = val[2:0];
      s2dconv_pkg::REG_IMAGE_ROWS:  i_rows_q = val[8:0];
      s2dconv_pkg::REG_IMAGE_COLS:  i_cols_q = val[8:0];
      s2dconv_pkg::REG_STRIDE:      stride_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int kr, input int kc, input int ir, input int ic,
                              input int s);
    write_reg(s2dconv_pkg::REG_KERNEL_ROWS, kr);
    write_reg(s2dconv_pkg::REG_KERNEL_COLS, kc);
    write_reg(s2dconv_pkg::REG_IMAGE_ROWS, ir);
    write_reg(s2dconv_pkg::REG_IMAGE_COLS, ic);
    write_reg(s2dconv_pkg::REG_STRIDE, s);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'sh8000;
    if (p == 1) return 16'sh7fff;
    return 16'($urandom());
  endfunction

  // Loads every weight slot, then sends whole frames of pixels.
  task automatic run_frames(input int frames);
    in_beat_t b;
    int n;
    for (int w = 0; w < 25; w++) begin
      b.cmd = s2dconv_pkg::CMD_WEIGHT; b.weight_index = 5'(w); b.value = rand_sample();
      send_beat(b);
    end
    n = frames * clampu(i_rows_q, 1, 256) * clampu(i_cols_q, 1, 256);
    for (int k = 0; k < n; k++) begin
      b.cmd = s2dconv_pkg::CMD_PIXEL; b.weight_index = 5'($urandom());
      b.value = rand_sample();
      // An occasional weight beat mid-frame, including ignored indexes.
      if ($urandom_range(0, 19) == 0) begin
        in_beat_t w;
        w.cmd = s2dconv_pkg::CMD_WEIGHT; w.weight_index = 5'($urandom());
        w.value = rand_sample();
        send_beat(w);
      end
      send_beat(b);
    end
  endtask

  // Result side: random stalls, compare each beat with the oldest window.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (window_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $realtime, out_data);
          errors++;
        end else begin
          out_beat_t e;
          e = window_q.pop_front();
          if (e.sum !== out_data.sum)
            $display("%0t: sum expected %0d actual %0d", $realtime, e.sum, out_data.sum);
          if (e.out_row !== out_data.out_row)
            $display("%0t: out_row expected %0d actual %0d", $realtime, e.out_row,
                     out_data.out_row);
          if (e.out_col !== out_data.out_col)
            $display("%0t: out_col expected %0d actual %0d", $realtime, e.out_col,
                     out_data.out_col);
          if (e.last !== out_data.last)
            $display("%0t: last expected %0b actual %0b", $realtime, e.last, out_data.last);
          if (e !== out_data) errors++;
        end
      end
      out_stall <= stall_mode ? ($urandom_range(0, 3) != 0)
                              : ($urandom_range(0, 99) < 25);
    end
  end

  // Directed table: beat and, where obvious, the typed-in result.
  typedef struct {
    in_beat_t  b;
    bit        chk;
    out_beat_t e;
  } row_t;

  initial begin
    row_t tbl [$];
    row_t t;
    out_beat_t got;
    for (int i = 0; i < 25; i++) weights_q[i] = 0;
    for (int i = 0; i < 1280; i++) lines_q[i] = 0;
    k_rows_q = 3; k_cols_q = 3; i_rows_q = 28; i_cols_q = 28; stride_q = 1;
    pos_row = 0; pos_col = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 1x1 kernel on a 2x2 image: each pixel times weight 0 gives a sum.
    set_geometry(1, 1, 2, 2, 1);
    t.chk = 0; t.e = '0;
    t.b = '{s2dconv_pkg::CMD_PIXEL, 5'd0, 16'sd1234}; t.chk = 1;
    t.e = '{37'sd0, 8'd0, 8'd0, 1'b0}; tbl = {tbl, t};  // weights zero after reset
    t.chk = 0;
    t.b = '{s2dconv_pkg::CMD_WEIGHT, 5'd0, 16'sh8000}; tbl = {tbl, t};
    t.b = '{s2dconv_pkg::CMD_WEIGHT, 5'd31, 16'sh7fff}; tbl = {tbl, t};  // ignored index
    t.b = '{s2dconv_pkg::CMD_WEIGHT, 5'd25, 16'sh0001}; tbl = {tbl, t};  // ignored index
    t.b = '{s2dconv_pkg::CMD_PIXEL, 5'd31, 16'sh8000}; t.chk = 1;
    t.e = '{37'sd1073741824, 8'd0, 8'd1, 1'b0}; tbl = {tbl, t};
    t.b = '{s2dconv_pkg::CMD_PIXEL, 5'd0, 16'sh7fff};
    t.e = '{-37'sd1073709056, 8'd1, 8'd0, 1'b0}; tbl = {tbl, t};
    t.b = '{s2dconv_pkg::CMD_PIXEL, 5'd0, 16'sd0};
    t.e = '{37'sd0, 8'd1, 8'd1, 1'b1}; tbl = {tbl, t};
    t.chk = 0;
    for (int i = 0; i < 12; i++) begin
      t.b = '{s2dconv_pkg::CMD_WEIGHT, 5'(i), (i % 2) ? 16'sh7fff : 16'sh8000};
      tbl = {tbl, t};
    end
    foreach (tbl[i]) begin
      send_beat(tbl[i].b);
      if (tbl[i].chk) begin
        got = pred_q;
        if (!pred_hit || got !== tbl[i].e) begin
          $display("%0t: directed row %0d expected %p actual %p", $realtime, i,
                   tbl[i].e, got);
          errors++;
        end
      end
    end
    drain();

    // Random phases through a spread of geometries, extremes included.
    set_geometry(5, 5, 5, 5, 5); run_frames(1); drain();        // one window
    set_geometry(5, 5, 3, 4, 1); run_frames(1); drain();        // kernel too big
    set_geometry(7, 0, 6, 9, 0); run_frames(1); drain();        // saturated fields
    stall_mode = 1'b1;
    set_geometry(3, 2, 9, 8, 2); run_frames(1); drain();        // non-dividing stride
    stall_mode = 1'b0;
    set_geometry(1, 5, 1, 256, 4); run_frames(1); drain();      // widest row
    set_geometry(5, 4, 0, 511, 7); drain();                     // saturates high
    set_geometry(2, 3, 5, 8, 3); run_frames(1); drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
